// ===== rtl/core/fdv_pkg.sv =====
// ----------------------------------------------------------------------------
// fdv_pkg: shared types and constants for the distinct value filter
// row and result payload structs, queue entry and scan state encoding
// ----------------------------------------------------------------------------
package fdv_pkg;

    localparam int unsigned TableDepthDefault = 256;
    localparam int unsigned ValueWidth        = 64;
    localparam int unsigned KeyWidth          = 8;
    localparam int unsigned CountWidth        = 9;
    localparam int unsigned QueueDepth        = 2;
    localparam int unsigned CfgIndexWidth     = 1;
    localparam int unsigned CfgDataWidth      = 8;

    localparam logic [CfgIndexWidth-1:0] CfgFilterEnable = 1'd0;
    localparam logic [CfgIndexWidth-1:0] CfgSelectKey    = 1'd1;

    typedef struct packed {
        logic [ValueWidth-1:0]      row_value;
        logic signed [KeyWidth-1:0] row_key;
        logic                       last_row;
    } t_row;

    typedef struct packed {
        logic                    kept;
        logic [ValueWidth-1:0]   out_value;
        logic [CountWidth-1:0]   distinct_count;
        logic                    overflow;
    } t_result;

    // classified row handed from front to back
    typedef struct packed {
        logic                  used;
        logic [ValueWidth-1:0] value;
        logic                  last_row;
    } t_job;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_WAIT,
        ST_DONE
    } t_state;

endpackage

// ===== rtl/core/fdv_stream_if.sv =====
// ----------------------------------------------------------------------------
// fdv_stream_if: valid/ready channel
// generic payload handshake with source and sink views
// ----------------------------------------------------------------------------
interface fdv_stream_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/core/filtered_distinct_values.sv =====
// a used row scans the stored values before its result is built; a filtered
// row skips the lookup; a duplicate ends as soon as its match is read back
// a row starts only after the previous result is taken; a two-entry queue
// buffers input
// reset (synchronous, active low) clears count, overflow, queue and config
// ----------------------------------------------------------------------------
// filtered_distinct_values: streaming select distinct with key filter
// keeps first occurrence of each value per column, sticky overflow when full
// ----------------------------------------------------------------------------
module filtered_distinct_values #(
    parameter int unsigned TABLE_DEPTH = fdv_pkg::TableDepthDefault
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_cfg_we,
    input  logic [fdv_pkg::CfgIndexWidth-1:0]     i_cfg_index,
    input  logic [fdv_pkg::CfgDataWidth-1:0]      i_cfg_data,
    fdv_stream_if.sink                            rows,
    fdv_stream_if.source                          results
);
    import fdv_pkg::*;

    logic                       r_filter_enable;
    logic signed [KeyWidth-1:0] r_select_key;
    logic                       job_valid, pop;
    t_job                       job;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_filter_enable <= 1'b0;
            r_select_key    <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CfgFilterEnable: r_filter_enable <= i_cfg_data[0];
                CfgSelectKey:    r_select_key    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    fdv_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_filter_enable (r_filter_enable),
        .i_select_key    (r_select_key),
        .rows            (rows),
        .i_pop           (pop),
        .o_job_valid     (job_valid),
        .o_job           (job)
    );

    fdv_back #(.TABLE_DEPTH(TABLE_DEPTH)) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (job_valid),
        .i_job       (job),
        .o_pop       (pop),
        .results     (results)
    );
endmodule

// ===== rtl/core/fdv_ram.sv =====
// ----------------------------------------------------------------------------
// fdv_ram: generic simple dual port ram
// one write port, one read port, registered read data
// ----------------------------------------------------------------------------
module fdv_ram #(
    parameter int unsigned WIDTH = 64,
    parameter int unsigned DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ===== rtl/core/fdv_front.sv =====
// ----------------------------------------------------------------------------
// fdv_front: row intake and key filter
// applies the key filter and pushes classified rows into a short queue
// ----------------------------------------------------------------------------
module fdv_front (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_filter_enable,
    input  logic signed [fdv_pkg::KeyWidth-1:0] i_select_key,
    fdv_stream_if.sink                        rows,
    input  logic                              i_pop,
    output logic                              o_job_valid,
    output fdv_pkg::t_job                     o_job
);
    import fdv_pkg::*;

    localparam int unsigned PtrW = $clog2(QueueDepth);

    t_job                r_q [QueueDepth];
    logic [PtrW-1:0]     r_wr, r_rd;
    logic [PtrW:0]       r_cnt;
    logic                push;
    t_job                job_in;

    assign rows.ready = (r_cnt != (PtrW+1)'(QueueDepth));
    assign push       = rows.valid && rows.ready;

    always_comb begin
        job_in.used     = !i_filter_enable || (rows.data.row_key == i_select_key);
        job_in.value    = rows.data.row_value;
        job_in.last_row = rows.data.last_row;
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wr] <= job_in;
        end
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            r_cnt <= r_cnt + (PtrW+1)'(push) - (PtrW+1)'(i_pop);
        end
    end

    assign o_job_valid = (r_cnt != '0);
    assign o_job       = r_q[r_rd];
endmodule

// ===== rtl/core/fdv_back.sv =====
// ----------------------------------------------------------------------------
// fdv_back: store lookup and insert
// scans stored values one per cycle, inserts new ones, builds the result
// ----------------------------------------------------------------------------
module fdv_back #(
    parameter int unsigned TABLE_DEPTH = fdv_pkg::TableDepthDefault
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_job_valid,
    input  fdv_pkg::t_job  i_job,
    output logic           o_pop,
    fdv_stream_if.source   results
);
    import fdv_pkg::*;

    localparam int unsigned AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);

    t_state          r_state, n_state;
    logic [CW-1:0]   r_count, n_count;
    logic            r_ovf, n_ovf;
    logic [CW-1:0]   r_idx, n_idx;
    logic            r_rd_pend;
    logic            r_hit, n_hit;
    t_job            r_job;
    t_result         r_res, n_res;
    logic            r_res_valid;
    logic            start, finish, ram_we;
    logic [ValueWidth-1:0] rdata;
    logic            rd_issue;

    fdv_ram #(.WIDTH(ValueWidth), .DEPTH(2 ** AW)) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_count[AW-1:0]),
        .i_wdata (r_job.value),
        .i_raddr (r_idx[AW-1:0]),
        .o_rdata (rdata)
    );

    assign start = (r_state == ST_IDLE) && i_job_valid && !r_res_valid;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: if (start) n_state = ST_SCAN;
            ST_SCAN: if (r_hit || (r_idx == r_count && !r_rd_pend)) n_state = ST_DONE;
                     else if (r_idx == r_count) n_state = ST_WAIT;
            ST_WAIT: n_state = ST_DONE;
            ST_DONE: n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    // outputs and datapath
    always_comb begin
        rd_issue = (r_state == ST_SCAN) && r_job.used && (r_idx != r_count) && !r_hit;
        n_idx    = rd_issue ? r_idx + 1'b1 : r_idx;
        n_hit    = r_hit || (r_rd_pend && (rdata == r_job.value));
        if (!r_job.used) n_hit = 1'b1;
        finish   = (r_state == ST_DONE);
        ram_we   = 1'b0;
        n_count  = r_count;
        n_ovf    = r_ovf;
        n_res.kept           = 1'b0;
        n_res.out_value      = '0;
        n_res.distinct_count = CountWidth'(r_count);
        n_res.overflow       = r_ovf;
        if (finish && !r_hit) begin
            if (r_count < CW'(TABLE_DEPTH)) begin
                ram_we          = 1'b1;
                n_count         = r_count + 1'b1;
                n_res.kept      = 1'b1;
                n_res.out_value = r_job.value;
            end else begin
                n_ovf = 1'b1;
            end
            n_res.distinct_count = CountWidth'(n_count);
            n_res.overflow       = n_ovf;
        end
        if (finish && r_job.last_row) begin
            n_count = '0;
            n_ovf   = 1'b0;
        end
    end

    assign o_pop = finish;

    always_ff @(posedge i_clk) begin
        if (start) begin
            r_job <= i_job;
        end
        if (finish) begin
            r_res <= n_res;
        end
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_ovf       <= 1'b0;
            r_idx       <= '0;
            r_rd_pend   <= 1'b0;
            r_hit       <= 1'b0;
            r_res_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_ovf     <= n_ovf;
            r_rd_pend <= rd_issue;
            if (start) begin
                r_idx <= '0;
                r_hit <= 1'b0;
            end else if (r_state == ST_SCAN || r_state == ST_WAIT) begin
                r_idx <= n_idx;
                r_hit <= n_hit;
            end
            if (finish) begin
                r_res_valid <= 1'b1;
            end else if (results.ready) begin
                r_res_valid <= 1'b0;
            end
        end
    end

    assign results.valid = r_res_valid;
    assign results.data  = r_res;
endmodule

// ===== test/tb_filtered_distinct_values.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_filtered_distinct_values: self-checking bench for the distinct value filter
// drives rows with random bursts and gaps, predicts each result from a local
// copy of the value store, and compares every result transaction field by field
// ----------------------------------------------------------------------------
module tb_filtered_distinct_values;
    import fdv_pkg::*;

    localparam int unsigned Depth     = 256;
    localparam int unsigned CycleLimit = 3_000_000;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic [CfgIndexWidth-1:0] i_cfg_index;
    logic [CfgDataWidth-1:0]  i_cfg_data;

    fdv_stream_if #(.T(t_row))    rows_if ();
    fdv_stream_if #(.T(t_result)) results_if ();

    filtered_distinct_values #(.TABLE_DEPTH(Depth)) u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .rows        (rows_if.sink),
        .results     (results_if.source)
    );

    // predictor state
    logic [ValueWidth-1:0]      seen_store [Depth];
    int unsigned                seen_count;
    logic                       dropped_flag;
    logic                       filter_on;
    logic signed [KeyWidth-1:0] match_key;

    t_row    pending_rows [$];
    t_result expected_results [$];
    int      error_count;
    int      result_count;
    int      kept_count;
    int      overflow_seen;
    longint  cycle_count;
    bit      hold_sink;
    bit      stimulus_done;
    bit      row_taken;

    always begin
        i_clk = 1'b1;
        #6;
        i_clk = 1'b0;
        #6;
    end

    function automatic t_result predict_distinct(t_row r);
        t_result res;
        bit      found;
        found = 1'b0;
        res = '0;
        if (!filter_on || r.row_key == match_key) begin
            for (int k = 0; k < seen_count; k++)
                if (seen_store[k] == r.row_value) found = 1'b1;
            if (!found) begin
                if (seen_count < Depth) begin
                    seen_store[seen_count] = r.row_value;
                    seen_count++;
                    res.kept = 1'b1;
                    res.out_value = r.row_value;
                end else begin
                    dropped_flag = 1'b1;
                end
            end
        end
        res.distinct_count = seen_count[CountWidth-1:0];
        res.overflow = dropped_flag;
        if (r.last_row) begin
            seen_count = 0;
            dropped_flag = 1'b0;
        end
        return res;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("mismatch in result %0d: %s got %h expected %h",
                 result_count, what, got, want);
        error_count++;
    endtask

    // driver: bursts and gaps
    int burst_left;
    int gap_left;
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            rows_if.valid <= 1'b0;
            burst_left <= 0;
            gap_left <= 0;
        end else if (rows_if.valid && !row_taken) begin
            // hold the offered row
        end else if (gap_left > 0) begin
            rows_if.valid <= 1'b0;
            gap_left <= gap_left - 1;
        end else if (pending_rows.size() > 0) begin
            rows_if.data <= pending_rows.pop_front();
            rows_if.valid <= 1'b1;
            if (burst_left == 0) begin
                burst_left <= $urandom_range(1, 30);
                if ($urandom_range(0, 2) == 0) gap_left <= $urandom_range(1, 6);
            end else begin
                burst_left <= burst_left - 1;
            end
        end else begin
            rows_if.valid <= 1'b0;
        end
    end

    // prediction on accepted rows, counted at the rising edge
    always @(posedge i_clk) begin
        row_taken <= i_rst_n && rows_if.valid && rows_if.ready;
        if (i_rst_n && rows_if.valid && rows_if.ready)
            expected_results.push_back(predict_distinct(rows_if.data));
    end

    // receiver stall pattern
    int stall_phase;
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            results_if.ready <= 1'b0;
            stall_phase <= 0;
        end else begin
            stall_phase <= stall_phase + 1;
            if (hold_sink) results_if.ready <= 1'b0;
            else if (stall_phase[9]) results_if.ready <= 1'b1;
            else results_if.ready <= ($urandom_range(0, 3) != 0);
        end
    end

    // monitor
    always @(posedge i_clk) begin
        t_result want;
        t_result got;
        if (i_rst_n && results_if.valid && results_if.ready) begin
            got = results_if.data;
            if (expected_results.size() == 0) begin
                $display("unexpected result transaction %0d", result_count);
                error_count++;
            end else begin
                want = expected_results.pop_front();
                if (got.kept !== want.kept) report_mismatch("kept", got.kept, want.kept);
                if (got.out_value !== want.out_value)
                    report_mismatch("out_value", got.out_value, want.out_value);
                if (got.distinct_count !== want.distinct_count)
                    report_mismatch("distinct_count", got.distinct_count,
                                    want.distinct_count);
                if (got.overflow !== want.overflow)
                    report_mismatch("overflow", got.overflow, want.overflow);
                if (want.kept) kept_count++;
                if (want.overflow) overflow_seen++;
            end
            result_count++;
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CycleLimit) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("CHECKS FAILED");
            $finish;
        end
    end

    function automatic t_row make_row(logic [63:0] v, logic [7:0] k, logic l);
        t_row r;
        r.row_value = v;
        r.row_key = k;
        r.last_row = l;
        return r;
    endfunction

    function automatic logic [63:0] rand_value();
        return {$urandom, $urandom};
    endfunction

    task automatic wait_drained();
        while (pending_rows.size() > 0 || rows_if.valid || expected_results.size() > 0)
            @(posedge i_clk);
        // a filtered row yields a result too, so an empty expected queue means every row is done
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CfgIndexWidth-1:0] idx,
                             input logic [CfgDataWidth-1:0] val);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == CfgFilterEnable) filter_on = val[0];
        else match_key = val;
    endtask

    // a column drawn from a small pool so duplicates are common
    task automatic queue_column(input int len, input int pool, input logic [7:0] key_bias);
        logic [63:0] vals [16];
        logic [7:0]  k;
        for (int i = 0; i < 16; i++) vals[i] = rand_value();
        for (int i = 0; i < len; i++) begin
            k = ($urandom_range(0, 1) == 0) ? key_bias : 8'($urandom);
            pending_rows.push_back(make_row(
                ($urandom_range(0, 3) == 0) ? rand_value() : vals[$urandom_range(0, pool - 1)],
                k, i == len - 1));
        end
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_index = '0;
        i_cfg_data = '0;
        rows_if.valid = 1'b0;
        rows_if.data = '0;
        results_if.ready = 1'b0;
        hold_sink = 1'b0;
        stimulus_done = 1'b0;
        row_taken = 1'b0;
        error_count = 0;
        result_count = 0;
        kept_count = 0;
        overflow_seen = 0;
        cycle_count = 0;
        seen_count = 0;
        dropped_flag = 1'b0;
        filter_on = 1'b0;
        match_key = '0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: extremes, duplicates, filtering, last row
        pending_rows.push_back(make_row(64'h0, 8'h80, 1'b0));
        pending_rows.push_back(make_row(64'hFFFF_FFFF_FFFF_FFFF, 8'h7F, 1'b0));
        pending_rows.push_back(make_row(64'h0, 8'h00, 1'b0));
        pending_rows.push_back(make_row(64'hFFFF_FFFF_FFFF_FFFF, 8'hFF, 1'b1));
        pending_rows.push_back(make_row(64'h0, 8'h00, 1'b0));
        pending_rows.push_back(make_row(64'hAAAA_AAAA_5555_5555, 8'h55, 1'b1));
        wait_drained();
        write_reg(CfgFilterEnable, 8'd1);
        write_reg(CfgSelectKey, 8'h80);
        pending_rows.push_back(make_row(64'h1234, 8'h80, 1'b0));
        pending_rows.push_back(make_row(64'h5678, 8'h7F, 1'b0));
        pending_rows.push_back(make_row(64'h1234, 8'h80, 1'b1));
        wait_drained();
        write_reg(CfgSelectKey, 8'h7F);
        pending_rows.push_back(make_row(64'h5678, 8'h7F, 1'b0));
        pending_rows.push_back(make_row(64'h9, 8'h80, 1'b1));
        wait_drained();
        write_reg(CfgFilterEnable, 8'd0);

        // store fill: 256 distinct, then drops with overflow, then a duplicate
        for (int i = 0; i < 260; i++)
            pending_rows.push_back(make_row(64'(i) * 64'h9E37_79B9 + 1, 8'($urandom), 1'b0));
        pending_rows.push_back(make_row(64'h1, 8'h00, 1'b0));
        pending_rows.push_back(make_row(64'hDEAD, 8'h00, 1'b1));
        wait_drained();

        // long receiver hold while rows keep coming
        hold_sink = 1'b1;
        queue_column(40, 8, 8'h00);
        repeat (300) @(posedge i_clk);
        hold_sink = 1'b0;
        wait_drained();

        // random phases over several settings
        for (int phase = 0; phase < 18; phase++) begin
            write_reg(CfgFilterEnable, 8'($urandom_range(0, 1)));
            write_reg(CfgSelectKey, (phase % 4 == 0) ? 8'h80 : (phase % 4 == 1) ? 8'h7F
                      : 8'($urandom));
            for (int c = 0; c < 6; c++)
                queue_column($urandom_range(1, 20), $urandom_range(1, 16), match_key);
            wait_drained();
        end
        stimulus_done = 1'b1;
        wait_drained();

        $display("ran %0d result transactions, %0d kept, %0d with overflow set",
                 result_count, kept_count, overflow_seen);
        $display("covered filter on and off, key extremes, full store and receiver hold");
        if (error_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("%0d errors", error_count);
            $display("CHECKS FAILED");
        end
        $finish;
    end
endmodule
